[rtl/core/cpdh_pkg.sv]
// ----------------------------------------------------------------------------
// cpdh_pkg - shared definitions for the channel pair deinterleave histogram
// Types, codes and sizing constants for the deinterleave and histogram unit.
// ----------------------------------------------------------------------------
package cpdh_pkg;

  // Default sizing for the histogram store
  localparam int CHANNELS_DEF = 16;
  localparam int BLOCKS_DEF   = 16;

  // Fixed histogram geometry: 64 bins from the top six bits of a sample
  localparam int BINS  = 64;
  localparam int BIN_W = 6;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int PAIR_W    = 3;
  localparam int SPI_W     = 20;
  localparam int CH_IN_W   = 4;
  localparam int ADDR_OUT_W = 24;
  localparam int COUNT_W   = 32;
  localparam int ABLK_W    = 4;
  localparam int HLEN_W    = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 1;

  // Sample to bin mapping
  localparam logic [HALF_W-1:0] SIGN_FLIP = 16'h8000;
  localparam int                BIN_SHIFT = 10;

  // Samples per word pair, one read-modify-write each
  localparam int SAMPLES = 4;
  localparam int STEP_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN     = 1'd1;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PROCESS = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_BUMP,
    S_RD_ISSUE,
    S_RD_CAPTURE,
    S_CLEAR,
    S_RESULT
  } state_t;

  // Bin of a 16-bit sample: flip the sign bit, keep the top six bits
  function automatic logic [BIN_W-1:0] bin_of(input logic [HALF_W-1:0] smp);
    logic [HALF_W-1:0] flipped;
    flipped = (smp ^ SIGN_FLIP) >> BIN_SHIFT;
    return flipped[BIN_W-1:0];
  endfunction

endpackage

[rtl/core/channel_pair_deinterleave_histogram_unit.sv]
// ----------------------------------------------------------------------------
// channel_pair_deinterleave_histogram_unit - 2x2 transpose with histograms
// Transposes a channel pair over two samples into per-channel words with
// channel-major addresses, and keeps 64-bin sample histograms per block.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall is high while it is worked on. A word
// pair makes four counter read-modify-writes in the single histogram memory,
// one read issued per cycle with the increment and write in the cycle after,
// then a drain step and the result state. A counter read passes the read
// issue, read capture and result states, a block clear zeroes the block's
// entries before the result state, and func code 3 goes straight to it. After
// reset the whole store (BLOCKS * 2^ceil(log2(CHANNELS)) * 64 entries, 16384
// by default) is cleared one entry per cycle before the first item is taken;
// configuration writes are taken throughout. A finished result waits in the
// output register and the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
module channel_pair_deinterleave_histogram_unit #(
  parameter int CHANNELS = cpdh_pkg::CHANNELS_DEF,
  parameter int BLOCKS   = cpdh_pkg::BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [cpdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpdh_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cpdh_pkg::FUNC_W-1:0]         func,
  input  logic [cpdh_pkg::WORD_W-1:0]         word_early,
  input  logic [cpdh_pkg::WORD_W-1:0]         word_late,
  input  logic [cpdh_pkg::PAIR_W-1:0]         pair_index,
  input  logic [cpdh_pkg::SPI_W-1:0]          sample_pair_index,
  input  logic [cpdh_pkg::CH_IN_W-1:0]        read_channel,
  input  logic [cpdh_pkg::BIN_W-1:0]          read_bin,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cpdh_pkg::WORD_W-1:0]         out_word_a,
  output logic [cpdh_pkg::ADDR_OUT_W-1:0]     out_addr_a,
  output logic [cpdh_pkg::WORD_W-1:0]         out_word_b,
  output logic [cpdh_pkg::ADDR_OUT_W-1:0]     out_addr_b,
  output logic [cpdh_pkg::COUNT_W-1:0]        counter_value
);

  localparam int CH_W      = $clog2(CHANNELS);
  localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CLR_W     = CH_W + cpdh_pkg::BIN_W;
  localparam int ADDR_W    = BLK_W + CLR_W;
  localparam int MEM_DEPTH = BLOCKS * (1 << CLR_W);
  localparam int BEXT_W    = BLK_W + cpdh_pkg::ABLK_W;
  localparam int CHX_W     = cpdh_pkg::CH_IN_W + 1;
  localparam int PROD_W    = cpdh_pkg::ADDR_OUT_W;

  localparam logic [ADDR_W-1:0] INIT_LAST  = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [CLR_W-1:0]  CLEAR_LAST = '1;
  localparam logic [cpdh_pkg::STEP_W-1:0] STEP_DRAIN =
    cpdh_pkg::STEP_W'(cpdh_pkg::SAMPLES);

  // Configuration registers
  logic [cpdh_pkg::ABLK_W-1:0] active_block;
  logic [cpdh_pkg::HLEN_W-1:0] half_len;

  // Sequencer
  cpdh_pkg::state_t              state, state_next;
  logic [cpdh_pkg::STEP_W-1:0]   step, step_next;
  logic [ADDR_W-1:0]             cursor, cursor_next;

  // Item registers
  logic [cpdh_pkg::FUNC_W-1:0]   func_q;
  logic [cpdh_pkg::WORD_W-1:0]   early_q, late_q;
  logic [cpdh_pkg::PAIR_W-1:0]   pair_q;
  logic [cpdh_pkg::SPI_W-1:0]    spi_q;
  logic [cpdh_pkg::CH_IN_W-1:0]  rch_q;
  logic [cpdh_pkg::BIN_W-1:0]    rbin_q;
  logic [cpdh_pkg::ADDR_OUT_W-1:0] addr_a_q, addr_b_q;
  logic [cpdh_pkg::COUNT_W-1:0]  count_q;

  // Histogram memory and its ports
  logic [cpdh_pkg::COUNT_W-1:0]  hist_mem [MEM_DEPTH];
  logic [cpdh_pkg::COUNT_W-1:0]  rd_data;
  logic [ADDR_W-1:0]             mem_raddr, mem_waddr;
  logic [cpdh_pkg::COUNT_W-1:0]  mem_wdata;
  logic                          mem_we;

  // Increment stage, one sample behind the read
  logic                          stg_vld;
  logic                          stg_en;
  logic [ADDR_W-1:0]             stg_addr;
  logic                          fwd;
  logic [cpdh_pkg::COUNT_W-1:0]  last_val;
  logic [cpdh_pkg::COUNT_W-1:0]  inc_val;
  logic                          issue;

  // Block and sample selection
  logic [BEXT_W-1:0]             blk_ext;
  logic [BLK_W-1:0]              blk;
  logic [cpdh_pkg::HALF_W-1:0]   smp;
  logic [cpdh_pkg::CH_IN_W-1:0]  smp_ch;
  logic                          smp_en;
  logic [ADDR_W-1:0]             smp_addr;
  logic                          rch_ok;
  logic                          accept;
  logic                          load_out;
  logic [PROD_W-1:0]             prod;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != cpdh_pkg::S_IDLE);

  // Fall back to block 0 when the active block is out of range
  assign blk_ext = BEXT_W'(active_block);
  assign blk     = (blk_ext < BEXT_W'(BLOCKS)) ? blk_ext[BLK_W-1:0] : '0;

  // Pick the sample for this step; channel a takes the low halves
  always_comb begin
    case (step[1:0])
      2'd0: begin
        smp    = early_q[cpdh_pkg::HALF_W-1:0];
        smp_ch = {pair_q, 1'b0};
      end
      2'd1: begin
        smp    = late_q[cpdh_pkg::HALF_W-1:0];
        smp_ch = {pair_q, 1'b0};
      end
      2'd2: begin
        smp    = early_q[cpdh_pkg::WORD_W-1:cpdh_pkg::HALF_W];
        smp_ch = {pair_q, 1'b1};
      end
      default: begin
        smp    = late_q[cpdh_pkg::WORD_W-1:cpdh_pkg::HALF_W];
        smp_ch = {pair_q, 1'b1};
      end
    endcase
  end

  assign smp_en   = CHX_W'(smp_ch) < CHX_W'(CHANNELS);
  assign smp_addr = {blk, smp_ch[CH_W-1:0], cpdh_pkg::bin_of(smp)};
  assign rch_ok   = CHX_W'(rch_q) < CHX_W'(CHANNELS);

  // Shared incrementer, taking the value just written when the address repeats
  assign inc_val = (fwd ? last_val : rd_data) + cpdh_pkg::COUNT_W'(1);
  assign issue   = (state == cpdh_pkg::S_BUMP) && (step != STEP_DRAIN);

  // Next state and memory control
  always_comb begin
    state_next = state;
    step_next  = step;
    cursor_next = cursor;
    mem_raddr  = smp_addr;
    mem_waddr  = stg_addr;
    mem_wdata  = inc_val;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      cpdh_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor;
        mem_wdata = '0;
        cursor_next = cursor + ADDR_W'(1);
        if (cursor == INIT_LAST) begin
          cursor_next = '0;
          state_next  = cpdh_pkg::S_IDLE;
        end
      end
      cpdh_pkg::S_IDLE: begin
        if (accept) begin
          step_next = '0;
          cursor_next = '0;
          case (func)
            cpdh_pkg::FUNC_PROCESS: state_next = cpdh_pkg::S_BUMP;
            cpdh_pkg::FUNC_READ:    state_next = cpdh_pkg::S_RD_ISSUE;
            cpdh_pkg::FUNC_CLEAR:   state_next = cpdh_pkg::S_CLEAR;
            default:                state_next = cpdh_pkg::S_RESULT;
          endcase
        end
      end
      cpdh_pkg::S_BUMP: begin
        mem_we    = stg_vld && stg_en;
        step_next = step + cpdh_pkg::STEP_W'(1);
        if (step == STEP_DRAIN) begin
          state_next = cpdh_pkg::S_RESULT;
        end
      end
      cpdh_pkg::S_RD_ISSUE: begin
        mem_raddr  = {blk, rch_q[CH_W-1:0], rbin_q};
        state_next = cpdh_pkg::S_RD_CAPTURE;
      end
      cpdh_pkg::S_RD_CAPTURE: begin
        state_next = cpdh_pkg::S_RESULT;
      end
      cpdh_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {blk, cursor[CLR_W-1:0]};
        mem_wdata = '0;
        cursor_next = cursor + ADDR_W'(1);
        if (cursor[CLR_W-1:0] == CLEAR_LAST) begin
          cursor_next = '0;
          state_next  = cpdh_pkg::S_RESULT;
        end
      end
      cpdh_pkg::S_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = cpdh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cpdh_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer registers; the clearing pass starts from reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cpdh_pkg::S_INIT;
      step   <= '0;
      cursor <= '0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      cursor <= cursor_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_block <= '0;
      half_len     <= cpdh_pkg::HLEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        cpdh_pkg::REG_ACTIVE_BLOCK: active_block <= cfg_data[cpdh_pkg::ABLK_W-1:0];
        cpdh_pkg::REG_HALF_LEN:     half_len     <= cfg_data[cpdh_pkg::HLEN_W-1:0];
        default:                    ;
      endcase
    end
  end

  // Histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= hist_mem[mem_raddr];
  end

  // Increment stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else begin
      stg_vld <= issue;
    end
  end

  // Increment stage payload; flag a repeat of the address being written now
  always_ff @(posedge clk) begin
    if (issue) begin
      stg_en   <= smp_en;
      stg_addr <= smp_addr;
      fwd      <= stg_vld && stg_en && (stg_addr == smp_addr);
    end
    if (stg_vld) begin
      last_val <= inc_val;
    end
  end

  // Capture the item and build its result fields
  assign prod = PROD_W'({pair_q, 1'b0}) * PROD_W'(half_len);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      early_q  <= word_early;
      late_q   <= word_late;
      pair_q   <= pair_index;
      spi_q    <= sample_pair_index;
      rch_q    <= read_channel;
      rbin_q   <= read_bin;
      addr_a_q <= '0;
      addr_b_q <= '0;
      count_q  <= '0;
    end
    if (state == cpdh_pkg::S_BUMP && step == '0) begin
      addr_a_q <= prod[cpdh_pkg::ADDR_OUT_W-1:0] + cpdh_pkg::ADDR_OUT_W'(spi_q);
    end
    if (state == cpdh_pkg::S_BUMP && step == cpdh_pkg::STEP_W'(1)) begin
      addr_b_q <= addr_a_q + cpdh_pkg::ADDR_OUT_W'(half_len);
    end
    if (state == cpdh_pkg::S_RD_CAPTURE) begin
      count_q <= rch_ok ? rd_data : '0;
    end
  end

  // Output register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (func_q == cpdh_pkg::FUNC_PROCESS) begin
        out_word_a <= {late_q[cpdh_pkg::HALF_W-1:0], early_q[cpdh_pkg::HALF_W-1:0]};
        out_word_b <= {late_q[cpdh_pkg::WORD_W-1:cpdh_pkg::HALF_W],
                       early_q[cpdh_pkg::WORD_W-1:cpdh_pkg::HALF_W]};
      end else begin
        out_word_a <= '0;
        out_word_b <= '0;
      end
      out_addr_a    <= addr_a_q;
      out_addr_b    <= addr_b_q;
      counter_value <= count_q;
    end
  end

endmodule

[rtl/core/cpdh_checker.sv]
// ----------------------------------------------------------------------------
// cpdh_checker - port-level checks for the deinterleave histogram unit
// Watches the item handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module cpdh_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [cpdh_pkg::WORD_W-1:0]         out_word_a,
  input logic [cpdh_pkg::ADDR_OUT_W-1:0]     out_addr_a,
  input logic [cpdh_pkg::WORD_W-1:0]         out_word_b,
  input logic [cpdh_pkg::ADDR_OUT_W-1:0]     out_addr_b,
  input logic [cpdh_pkg::COUNT_W-1:0]        counter_value
);

  // Hold off items while the store is swept after reset
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("item taken during the clearing pass");

  // Take one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in flight");

  // A counter read carries no words or addresses
  a_read_only_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counter_value != '0) |->
      (out_word_a == '0 && out_addr_a == '0 && out_word_b == '0 && out_addr_b == '0))
    else $error("counter result with non-zero word fields");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(counter_value)))
    else $error("stalled result dropped or changed");

endmodule

bind channel_pair_deinterleave_histogram_unit cpdh_checker u_cpdh_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_word_a    (out_word_a),
  .out_addr_a    (out_addr_a),
  .out_word_b    (out_word_b),
  .out_addr_b    (out_addr_b),
  .counter_value (counter_value)
);

[tb/cpdh_checker.sv]
// ----------------------------------------------------------------------------
// cpdh_result_checker - result predictor and comparator for the deinterleave unit
// Watches the register port and both item channels. It keeps its own copy
// of the histogram store and registers, predicts each result and compares
// every delivered result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cpdh_result_checker
  import cpdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [WORD_W-1:0]     word_early,
  input  logic [WORD_W-1:0]     word_late,
  input  logic [PAIR_W-1:0]     pair_index,
  input  logic [SPI_W-1:0]      sample_pair_index,
  input  logic [CH_IN_W-1:0]    read_channel,
  input  logic [BIN_W-1:0]      read_bin,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [WORD_W-1:0]     out_word_a,
  input  logic [ADDR_OUT_W-1:0] out_addr_a,
  input  logic [WORD_W-1:0]     out_word_b,
  input  logic [ADDR_OUT_W-1:0] out_addr_b,
  input  logic [COUNT_W-1:0]    counter_value,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0]     word_a;
    logic [ADDR_OUT_W-1:0] addr_a;
    logic [WORD_W-1:0]     word_b;
    logic [ADDR_OUT_W-1:0] addr_b;
    logic [COUNT_W-1:0]    count;
  } pair_result_t;

  // Shadow copy of the histogram store and the registers
  logic [COUNT_W-1:0] count_store [BLOCKS_DEF][CHANNELS_DEF][BINS];
  logic [ABLK_W-1:0]  active_block;
  logic [HLEN_W-1:0]  half_len;
  pair_result_t       expected_results [$];

  // Bump one counter; channels beyond the store are dropped
  function automatic void tally(input int unsigned blk, input int unsigned ch,
                                input logic [HALF_W-1:0] smp);
    logic [BIN_W-1:0] slot;
    if (ch >= CHANNELS_DEF) return;
    slot = smp[HALF_W-1 -: BIN_W] ^ 6'b100000;
    count_store[blk][ch][slot] = count_store[blk][ch][slot] + 1'b1;
  endfunction

  // Work out the result of one item and apply its effect on the store
  function automatic pair_result_t transpose_and_count(
    input logic [FUNC_W-1:0]  fn,
    input logic [WORD_W-1:0]  early,
    input logic [WORD_W-1:0]  late,
    input logic [PAIR_W-1:0]  pair,
    input logic [SPI_W-1:0]   spi,
    input logic [CH_IN_W-1:0] rch,
    input logic [BIN_W-1:0]   rbin
  );
    pair_result_t r;
    int unsigned  blk;
    int unsigned  ch;
    int unsigned  b;
    logic [31:0]  span;
    r   = '0;
    blk = (active_block < BLOCKS_DEF) ? active_block : 0;
    case (fn)
      FUNC_PROCESS: begin
        r.word_a = {late[HALF_W-1:0], early[HALF_W-1:0]};
        r.word_b = {late[WORD_W-1:HALF_W], early[WORD_W-1:HALF_W]};
        span     = 32'd2 * pair * half_len + spi;
        r.addr_a = span[ADDR_OUT_W-1:0];
        r.addr_b = r.addr_a + half_len;
        ch       = 2 * pair;
        tally(blk, ch, late[HALF_W-1:0]);
        tally(blk, ch, early[HALF_W-1:0]);
        tally(blk, ch + 1, late[WORD_W-1:HALF_W]);
        tally(blk, ch + 1, early[WORD_W-1:HALF_W]);
      end
      FUNC_READ: begin
        if (rch < CHANNELS_DEF) r.count = count_store[blk][rch][rbin];
      end
      FUNC_CLEAR: begin
        for (ch = 0; ch < CHANNELS_DEF; ch++)
          for (b = 0; b < BINS; b++) count_store[blk][ch][b] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare delivered results first, then record the newly accepted item
  always @(posedge clk) begin
    pair_result_t want;
    if (rst) begin
      foreach (count_store[i, j, k]) count_store[i][j][k] = '0;
      active_block = '0;
      half_len     = HLEN_W'(1);
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ACTIVE_BLOCK: active_block = cfg_data[ABLK_W-1:0];
          REG_HALF_LEN:     half_len     = cfg_data[HLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no item outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_word_a", want.word_a, out_word_a);
          check_field("out_addr_a", 32'(want.addr_a), 32'(out_addr_a));
          check_field("out_word_b", want.word_b, out_word_b);
          check_field("out_addr_b", 32'(want.addr_b), 32'(out_addr_b));
          check_field("counter_value", want.count, counter_value);
          results_checked++;
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(transpose_and_count(func, word_early, word_late,
          pair_index, sample_pair_index, read_channel, read_bin));
    end
    outstanding <= expected_results.size();
  end

endmodule

[tb/channel_pair_deinterleave_histogram_unit_test.sv]
// ----------------------------------------------------------------------------
// channel_pair_deinterleave_histogram_unit_test - top of the unit testbench
// Drives directed and random word pairs, counter reads and block clears
// through the unit under several register settings and idling patterns,
// including a long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module channel_pair_deinterleave_histogram_unit_test;
  import cpdh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Code the unit ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [BIN_W-1:0]  BIN_SIGN    = 6'b100000;
  localparam int                HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func;
  logic [WORD_W-1:0]     word_early;
  logic [WORD_W-1:0]     word_late;
  logic [PAIR_W-1:0]     pair_index;
  logic [SPI_W-1:0]      sample_pair_index;
  logic [CH_IN_W-1:0]    read_channel;
  logic [BIN_W-1:0]      read_bin;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_W-1:0]     out_word_a;
  logic [ADDR_OUT_W-1:0] out_addr_a;
  logic [WORD_W-1:0]     out_word_b;
  logic [ADDR_OUT_W-1:0] out_addr_b;
  logic [COUNT_W-1:0]    counter_value;

  int mismatches;
  int outstanding;
  int results_checked;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int n_process;
  int n_read;
  int n_clear;
  int n_ignored;

  channel_pair_deinterleave_histogram_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .word_early(word_early), .word_late(word_late), .pair_index(pair_index),
    .sample_pair_index(sample_pair_index), .read_channel(read_channel),
    .read_bin(read_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word_a(out_word_a), .out_addr_a(out_addr_a),
    .out_word_b(out_word_b), .out_addr_b(out_addr_b),
    .counter_value(counter_value)
  );

  cpdh_result_checker result_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .word_early(word_early), .word_late(word_late), .pair_index(pair_index),
    .sample_pair_index(sample_pair_index), .read_channel(read_channel),
    .read_bin(read_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word_a(out_word_a), .out_addr_a(out_addr_a),
    .out_word_b(out_word_b), .out_addr_b(out_addr_b),
    .counter_value(counter_value),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Write one register, then leave the port idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item after a random gap and hold it until taken
  task automatic offer(input logic [FUNC_W-1:0] fn, input logic [WORD_W-1:0] early,
                       input logic [WORD_W-1:0] late, input logic [PAIR_W-1:0] pair,
                       input logic [SPI_W-1:0] spi, input logic [CH_IN_W-1:0] rch,
                       input logic [BIN_W-1:0] rbin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    func              <= fn;
    word_early        <= early;
    word_late         <= late;
    pair_index        <= pair;
    sample_pair_index <= spi;
    read_channel      <= rch;
    read_bin          <= rbin;
    do @(posedge clk); while (in_stall);
    case (fn)
      FUNC_PROCESS: n_process++;
      FUNC_READ:    n_read++;
      FUNC_CLEAR:   n_clear++;
      default:      n_ignored++;
    endcase
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  // Bins that random samples keep landing in, so reads see real counts
  function automatic logic [BIN_W-1:0] hot_bin();
    case ($urandom_range(3))
      0:       return 6'd0;
      1:       return 6'd31;
      2:       return 6'd32;
      default: return 6'd63;
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] pick_sample();
    if ($urandom_range(1)) return 16'($urandom);
    return {hot_bin() ^ BIN_SIGN, 10'($urandom)};
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin();
    if ($urandom_range(9) < 6) return hot_bin();
    return 6'($urandom);
  endfunction

  // Random mix: mostly word pairs, plenty of reads, few clears
  task automatic random_items(input int count);
    int done;
    int roll;
    int pick;
    logic [FUNC_W-1:0] fn;
    logic [SPI_W-1:0]  spi;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 68)      fn = FUNC_PROCESS;
      else if (roll < 90) fn = FUNC_READ;
      else if (roll < 93) fn = FUNC_CLEAR;
      else                fn = FUNC_UNUSED;
      pick = $urandom_range(9);
      spi  = (pick == 0) ? '0 : (pick == 1) ? '1 : SPI_W'($urandom);
      offer(fn, {pick_sample(), pick_sample()}, {pick_sample(), pick_sample()},
            PAIR_W'($urandom_range(7)), spi, CH_IN_W'($urandom_range(15)), pick_bin());
      done++;
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    func              = FUNC_PROCESS;
    word_early        = '0;
    word_late         = '0;
    pair_index        = '0;
    sample_pair_index = '0;
    read_channel      = '0;
    read_bin          = '0;
    hold_requests     = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    n_process         = 0;
    n_read            = 0;
    n_clear           = 0;
    n_ignored         = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme samples and bins, reads, clear, ignored code
    write_reg(REG_ACTIVE_BLOCK, CFG_DATA_W'(0));
    write_reg(REG_HALF_LEN, CFG_DATA_W'(1));
    offer(FUNC_PROCESS, 32'h0000_0000, 32'h0000_0000, 3'd0, 20'h00000, 4'd0, 6'd0);
    offer(FUNC_PROCESS, 32'hffff_ffff, 32'hffff_ffff, 3'd7, 20'hfffff, 4'd15, 6'd63);
    offer(FUNC_PROCESS, 32'h8000_7fff, 32'h7fff_8000, 3'd3, 20'haaaaa, 4'd0, 6'd0);
    offer(FUNC_PROCESS, 32'h1234_5678, 32'h9abc_def0, 3'd1, 20'h55555, 4'd0, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd0, 6'd32);
    offer(FUNC_READ, '1, '1, 3'd7, '1, 4'd15, 6'd31);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd6, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd7, 6'd63);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd15, 6'd63);
    offer(FUNC_UNUSED, '1, '1, 3'd7, '1, 4'd15, 6'd63);
    offer(FUNC_UNUSED, 32'h5a5a_a5a5, 32'hc3c3_3c3c, 3'd2, 20'h12345, 4'd9, 6'd17);
    offer(FUNC_CLEAR, '0, '0, 3'd0, '0, 4'd0, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd0, 6'd32);
    offer(FUNC_PROCESS, 32'h0000_0000, 32'h0000_0000, 3'd0, 20'h00001, 4'd0, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd0, 6'd32);
    drain();

    // Top block, zero half length
    write_reg(REG_ACTIVE_BLOCK, CFG_DATA_W'(15));
    write_reg(REG_HALF_LEN, CFG_DATA_W'(0));
    offer(FUNC_PROCESS, 32'hffff_ffff, 32'h0000_0000, 3'd7, 20'hfffff, 4'd0, 6'd0);
    offer(FUNC_PROCESS, 32'h0000_0000, 32'hffff_ffff, 3'd7, 20'h00000, 4'd0, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd14, 6'd31);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd15, 6'd32);
    offer(FUNC_CLEAR, '0, '0, 3'd0, '0, 4'd0, 6'd0);
    offer(FUNC_READ, '0, '0, 3'd0, '0, 4'd14, 6'd31);
    drain();

    // Random, slow receiver, half length past its range
    write_reg(REG_ACTIVE_BLOCK, CFG_DATA_W'(5));
    write_reg(REG_HALF_LEN, 21'h1f_ffff);
    send_idle_pct  = 6;
    recv_stall_pct = 75;
    random_items(300);
    drain();

    // Random, slow sender, largest legal half length
    write_reg(REG_ACTIVE_BLOCK, CFG_DATA_W'(15));
    write_reg(REG_HALF_LEN, 21'd1048576);
    send_idle_pct  = 75;
    recv_stall_pct = 6;
    random_items(300);
    drain();

    // Random at full rate back in block 0, with one long output hold-off
    write_reg(REG_ACTIVE_BLOCK, CFG_DATA_W'(0));
    write_reg(REG_HALF_LEN, CFG_DATA_W'($urandom_range(1048576, 1)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_items(100);
    hold_requests++;
    random_items(230);
    drain();

    $display("Covered %0d word pairs, %0d counter reads, %0d block clears and %0d ignored items",
             n_process, n_read, n_clear, n_ignored);
    $display("%0d results checked over five register settings and a %0d-cycle hold-off",
             results_checked, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
